### rtl/gbrd_pkg.sv
package gbrd_pkg;

	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int CELLS      = MAX_ROWS * MAX_COLS;
	localparam int CELL_W     = $clog2(CELLS);
	localparam int QCNT_W     = $clog2(CELLS + 1);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int QW         = ROW_W + COL_W;
	localparam int DIM_W      = $clog2((MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 1);
	localparam int CFG_POS_W  = 4;
	localparam int CFG_DIM_W  = 5;
	localparam int CMP_W      = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
	localparam int LIN_W      = ROW_W + DIM_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_START_ROW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_COL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_USED  = 3'd5;

	typedef enum logic [2:0] {
		DIR_NONE  = 3'd0,
		DIR_DOWN  = 3'd1,
		DIR_UP    = 3'd2,
		DIR_RIGHT = 3'd3,
		DIR_LEFT  = 3'd4
	} entry_dir_t;

	typedef enum logic [1:0] {
		MOVE_UP    = 2'd0,
		MOVE_DOWN  = 2'd1,
		MOVE_LEFT  = 2'd2,
		MOVE_RIGHT = 2'd3
	} move_t;

	typedef struct packed {
		logic wall_bit;
		logic last_cell;
	} cell_t;

	typedef struct packed {
		logic       reachable;
		entry_dir_t entry_dir;
	} result_t;

	typedef struct packed {
		logic load_wr;
		logic init;
		logic pop;
		logic cap;
		logic wreq;
		logic wchk;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic q_empty;
		logic start_oob;
		logic nb_oob;
		logic last_dir;
	} stat_t;

	// 0 acts as 1, larger than the grid saturates
	function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DIM_W-1:0] v,
			logic [DIM_W-1:0] hi);
		logic [CMP_W-1:0] ve;
		logic [CMP_W-1:0] he;
		ve = CMP_W'(v);
		he = CMP_W'(hi);
		if (ve == '0)
			return DIM_W'(1);
		if (ve > he)
			return hi;
		return DIM_W'(ve);
	endfunction

	function automatic logic [CELL_W-1:0] lin_idx(logic [ROW_W-1:0] r,
			logic [COL_W-1:0] c, logic [DIM_W-1:0] nc);
		logic [LIN_W-1:0] p;
		p = LIN_W'(r) * LIN_W'(nc);
		return CELL_W'(p + LIN_W'(c));
	endfunction

	function automatic entry_dir_t dir_code(move_t m);
		entry_dir_t d;
		case (m)
			MOVE_UP:    d = DIR_UP;
			MOVE_DOWN:  d = DIR_DOWN;
			MOVE_LEFT:  d = DIR_LEFT;
			MOVE_RIGHT: d = DIR_RIGHT;
			default:    d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage

### rtl/grid_bfs_reach_direction_core.sv
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------
// map_cell  | start & !busy              | cell_t: wall_bit, last_cell
// result    | done (one-cycle strobe)    | result_t: reachable, entry_dir
// config    | cfg_valid & cfg_ready      | cfg_index, cfg_data
//
// A map cell with last_cell low leaves busy low, so cells stream at one a cycle.
// The last cell starts the search: each dequeued cell probes its neighbors in turn, an in-bounds
// probe with a wall-RAM read and a check, an out-of-bounds one without the check.
// Reset: asynchronous, active low; the visited map is a flop vector cleared at once, no sweep.
// The result is shown for the single cycle of done; the receiver cannot stall.
module grid_bfs_reach_direction_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  gbrd_pkg::cell_t                  map_cell,
	output logic                             done,
	output gbrd_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gbrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	gbrd_pkg::cmd_t  cmd;
	gbrd_pkg::stat_t stat;

	// the user must issue config transfers only while idle; the block does not enforce this
	assign cfg_ready = 1'b1;

	gbrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.map_cell (map_cell),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	gbrd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.map_cell  (map_cell),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result)
	);

endmodule

### rtl/gbrd_ram.sv
module gbrd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### rtl/gbrd_ctrl.sv
module gbrd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gbrd_pkg::cell_t map_cell,
	input  gbrd_pkg::stat_t stat,
	output gbrd_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_INIT = 8'b0000_0010,
		S_POP  = 8'b0000_0100,
		S_LOAD = 8'b0000_1000,
		S_WREQ = 8'b0001_0000,
		S_WCHK = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_RES  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_RES);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && map_cell.last_cell)
					state_d = S_INIT;
			end
			S_INIT: begin
				state_d = stat.start_oob ? S_FIN : S_POP;
			end
			S_POP: begin
				state_d = stat.q_empty ? S_FIN : S_LOAD;
			end
			S_LOAD: begin
				state_d = S_WREQ;
			end
			S_WREQ: begin
				if (!stat.nb_oob)
					state_d = S_WCHK;
				else if (stat.last_dir)
					state_d = S_POP;
			end
			S_WCHK: begin
				state_d = stat.last_dir ? S_POP : S_WREQ;
			end
			S_FIN: begin
				state_d = S_RES;
			end
			S_RES: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.load_wr = (state_q == S_IDLE) && accept;
		cmd.init    = (state_q == S_INIT);
		cmd.pop     = (state_q == S_POP) && !stat.q_empty;
		cmd.cap     = (state_q == S_LOAD);
		cmd.wreq    = (state_q == S_WREQ);
		cmd.wchk    = (state_q == S_WCHK);
		cmd.fin     = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_last_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && map_cell.last_cell) |=> (busy && !done))
		else $error("last cell transfer did not start a search");

endmodule

### rtl/gbrd_dp.sv
module gbrd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbrd_pkg::cmd_t                      cmd,
	input  gbrd_pkg::cell_t                     map_cell,
	input  logic                                cfg_valid,
	input  logic [gbrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gbrd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output gbrd_pkg::stat_t                     stat,
	output gbrd_pkg::result_t                   result
);

	logic [gbrd_pkg::CFG_POS_W-1:0] start_row_q, start_col_q, target_row_q, target_col_q;
	logic [gbrd_pkg::CFG_DIM_W-1:0] rows_used_q, cols_used_q;

	logic [gbrd_pkg::DIM_W-1:0]  nr, nc;
	logic [gbrd_pkg::CELL_W-1:0] load_idx_q;
	logic [gbrd_pkg::CELLS-1:0]  visited_q;
	logic [gbrd_pkg::CELLS-1:0]  start_mask;
	logic [gbrd_pkg::QCNT_W-1:0] head_q, tail_q;

	logic [gbrd_pkg::ROW_W-1:0]  cur_row_q, nb_row, nb_row_q;
	logic [gbrd_pkg::COL_W-1:0]  cur_col_q, nb_col, nb_col_q;
	gbrd_pkg::move_t             dir_q;
	logic                        nb_oob;
	logic [gbrd_pkg::CELL_W-1:0] nb_lin, nb_lin_q;

	logic                        start_oob, target_oob;
	logic [gbrd_pkg::ROW_W-1:0]  start_r, target_r;
	logic [gbrd_pkg::COL_W-1:0]  start_c, target_c;
	logic [gbrd_pkg::CELL_W-1:0] start_lin, target_lin;

	logic                        wall_rdata;
	logic [1:0]                  par_rdata;
	logic [gbrd_pkg::QW-1:0]     q_rdata, q_wdata;
	logic [gbrd_pkg::CELL_W-1:0] q_waddr;
	logic                        q_we, take;
	logic                        reach_q, same_q;

	assign nr = gbrd_pkg::clamp_dim(rows_used_q, gbrd_pkg::DIM_W'(gbrd_pkg::MAX_ROWS));
	assign nc = gbrd_pkg::clamp_dim(cols_used_q, gbrd_pkg::DIM_W'(gbrd_pkg::MAX_COLS));

	assign start_oob  = (gbrd_pkg::CMP_W'(start_row_q) >= gbrd_pkg::CMP_W'(nr))
		|| (gbrd_pkg::CMP_W'(start_col_q) >= gbrd_pkg::CMP_W'(nc));
	assign target_oob = (gbrd_pkg::CMP_W'(target_row_q) >= gbrd_pkg::CMP_W'(nr))
		|| (gbrd_pkg::CMP_W'(target_col_q) >= gbrd_pkg::CMP_W'(nc));
	assign start_r    = gbrd_pkg::ROW_W'(start_row_q);
	assign start_c    = gbrd_pkg::COL_W'(start_col_q);
	assign target_r   = gbrd_pkg::ROW_W'(target_row_q);
	assign target_c   = gbrd_pkg::COL_W'(target_col_q);
	assign start_lin  = start_oob ? '0 : gbrd_pkg::lin_idx(start_r, start_c, nc);
	assign target_lin = target_oob ? '0 : gbrd_pkg::lin_idx(target_r, target_c, nc);

	// fresh visited map for a search: only the start cell, if it is on the grid
	always_comb begin
		start_mask            = '0;
		start_mask[start_lin] = !start_oob;
	end

	// neighbor of the cell being expanded, in the move order up, down, left, right
	always_comb begin
		nb_row = cur_row_q;
		nb_col = cur_col_q;
		nb_oob = 1'b0;
		case (dir_q)
			gbrd_pkg::MOVE_UP: begin
				nb_oob = (cur_row_q == '0);
				nb_row = cur_row_q - gbrd_pkg::ROW_W'(1);
			end
			gbrd_pkg::MOVE_DOWN: begin
				nb_oob = (gbrd_pkg::CMP_W'(cur_row_q) + gbrd_pkg::CMP_W'(1))
					>= gbrd_pkg::CMP_W'(nr);
				nb_row = cur_row_q + gbrd_pkg::ROW_W'(1);
			end
			gbrd_pkg::MOVE_LEFT: begin
				nb_oob = (cur_col_q == '0);
				nb_col = cur_col_q - gbrd_pkg::COL_W'(1);
			end
			gbrd_pkg::MOVE_RIGHT: begin
				nb_oob = (gbrd_pkg::CMP_W'(cur_col_q) + gbrd_pkg::CMP_W'(1))
					>= gbrd_pkg::CMP_W'(nc);
				nb_col = cur_col_q + gbrd_pkg::COL_W'(1);
			end
			default: begin
				nb_oob = 1'b1;
			end
		endcase
		nb_lin = nb_oob ? '0 : gbrd_pkg::lin_idx(nb_row, nb_col, nc);
	end

	assign take = cmd.wchk && !wall_rdata && !visited_q[nb_lin_q];

	always_comb begin
		q_we    = 1'b0;
		q_waddr = tail_q[gbrd_pkg::CELL_W-1:0];
		q_wdata = {nb_row_q, nb_col_q};
		if (cmd.init) begin
			q_we    = !start_oob;
			q_waddr = '0;
			q_wdata = {start_r, start_c};
		end else if (take && (tail_q < gbrd_pkg::QCNT_W'(gbrd_pkg::CELLS))) begin
			q_we = 1'b1;
		end
	end

	assign stat.q_empty   = (head_q == tail_q);
	assign stat.start_oob = start_oob;
	assign stat.nb_oob    = nb_oob;
	assign stat.last_dir  = (dir_q == gbrd_pkg::MOVE_RIGHT);

	assign result.reachable = reach_q;
	assign result.entry_dir = (reach_q && !same_q)
		? gbrd_pkg::dir_code(gbrd_pkg::move_t'(par_rdata)) : gbrd_pkg::DIR_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q  <= 4'd1;
			start_col_q  <= 4'd1;
			target_row_q <= 4'd8;
			target_col_q <= 4'd8;
			rows_used_q  <= 5'd10;
			cols_used_q  <= 5'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				gbrd_pkg::REG_START_ROW:  start_row_q  <= cfg_data[gbrd_pkg::CFG_POS_W-1:0];
				gbrd_pkg::REG_START_COL:  start_col_q  <= cfg_data[gbrd_pkg::CFG_POS_W-1:0];
				gbrd_pkg::REG_TARGET_ROW: target_row_q <= cfg_data[gbrd_pkg::CFG_POS_W-1:0];
				gbrd_pkg::REG_TARGET_COL: target_col_q <= cfg_data[gbrd_pkg::CFG_POS_W-1:0];
				gbrd_pkg::REG_ROWS_USED:  rows_used_q  <= cfg_data;
				gbrd_pkg::REG_COLS_USED:  cols_used_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q <= '0;
			visited_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			dir_q      <= gbrd_pkg::MOVE_UP;
		end else begin
			if (cmd.load_wr) begin
				if (map_cell.last_cell
						|| (load_idx_q == gbrd_pkg::CELL_W'(gbrd_pkg::CELLS - 1)))
					load_idx_q <= '0;
				else
					load_idx_q <= load_idx_q + gbrd_pkg::CELL_W'(1);
			end
			if (cmd.init) begin
				visited_q <= start_mask;
				head_q    <= '0;
				tail_q    <= start_oob ? '0 : gbrd_pkg::QCNT_W'(1);
			end
			if (cmd.pop)
				head_q <= head_q + gbrd_pkg::QCNT_W'(1);
			if (cmd.cap)
				dir_q <= gbrd_pkg::MOVE_UP;
			if ((cmd.wreq && nb_oob) || cmd.wchk)
				dir_q <= gbrd_pkg::move_t'(dir_q + 2'd1);
			if (take) begin
				visited_q[nb_lin_q] <= 1'b1;
				if (tail_q < gbrd_pkg::QCNT_W'(gbrd_pkg::CELLS))
					tail_q <= tail_q + gbrd_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cur_row_q <= q_rdata[gbrd_pkg::QW-1:gbrd_pkg::COL_W];
			cur_col_q <= q_rdata[gbrd_pkg::COL_W-1:0];
		end
		if (cmd.wreq) begin
			nb_row_q <= nb_row;
			nb_col_q <= nb_col;
			nb_lin_q <= nb_lin;
		end
		if (cmd.fin) begin
			reach_q <= !target_oob && visited_q[target_lin];
			same_q  <= (target_row_q == start_row_q) && (target_col_q == start_col_q);
		end
	end

	gbrd_ram #(.WIDTH(1), .DEPTH(gbrd_pkg::CELLS)) u_wall (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (load_idx_q),
		.wdata (map_cell.wall_bit),
		.re    (cmd.wreq),
		.raddr (nb_lin),
		.rdata (wall_rdata)
	);

	gbrd_ram #(.WIDTH(2), .DEPTH(gbrd_pkg::CELLS)) u_parent (
		.clk   (clk),
		.we    (take),
		.waddr (nb_lin_q),
		.wdata (dir_q),
		.re    (cmd.fin),
		.raddr (target_lin),
		.rdata (par_rdata)
	);

	gbrd_ram #(.WIDTH(gbrd_pkg::QW), .DEPTH(gbrd_pkg::CELLS)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (cmd.pop),
		.raddr (head_q[gbrd_pkg::CELL_W-1:0]),
		.rdata (q_rdata)
	);

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= gbrd_pkg::QCNT_W'(gbrd_pkg::CELLS))
		else $error("queue tail past capacity");

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_init_one_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.init && !start_oob) |=> ($countones(visited_q) == 1))
		else $error("visited map not reduced to the start cell");

endmodule

### tb/sv/tb_grid_bfs_reach_direction_core.sv
module tb_grid_bfs_reach_direction_core;
	import gbrd_pkg::*;

	localparam int SETTLE     = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int RAND_ITEMS = 900;
	localparam int BIG_MAP    = 12;
	localparam int N_REGS     = 6;

	// indexes past the register file, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_COLS_USED + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP      = '1;

	// directed rows; wr_val = {cols, rows, target_col, target_row, start_col, start_row}
	typedef struct packed {
		logic [N_REGS-1:0]   wr_mask;
		logic [N_REGS*5-1:0] wr_val;
		logic [2:0]          len;
		logic [3:0]          walls;
		logic                known;
		result_t             want;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [10] = '{
		// reset start/target, 2x2 grid: target off the grid
		'{6'b110000, {5'd2, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0}, 3'd4, 4'b0000, 1'b1, '{1'b0, DIR_NONE}},
		'{6'b001111, {5'd0, 5'd0, 5'd1, 5'd1, 5'd0, 5'd0}, 3'd4, 4'b0000, 1'b0, '{1'b0, DIR_NONE}},
		'{6'b001111, {5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1}, 3'd1, 4'b0000, 1'b0, '{1'b0, DIR_NONE}},
		'{6'b000011, {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1}, 3'd1, 4'b0000, 1'b0, '{1'b0, DIR_NONE}},
		'{6'b001111, {5'd0, 5'd0, 5'd1, 5'd1, 5'd1, 5'd0}, 3'd1, 4'b0000, 1'b0, '{1'b0, DIR_NONE}},
		// start on a wall
		'{6'b001111, {5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0}, 3'd1, 4'b0001, 1'b0, '{1'b0, DIR_NONE}},
		// walled off
		'{6'b001100, {5'd0, 5'd0, 5'd1, 5'd1, 5'd0, 5'd0}, 3'd4, 4'b0110, 1'b1, '{1'b0, DIR_NONE}},
		// start off the grid
		'{6'b000001, {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31}, 3'd1, 4'b0000, 1'b1, '{1'b0, DIR_NONE}},
		// target off the grid
		'{6'b001101, {5'd0, 5'd0, 5'd16, 5'd15, 5'd0, 5'd0}, 3'd1, 4'b0000, 1'b1, '{1'b0, DIR_NONE}},
		// zero dims act as 1x1, start on target
		'{6'b111100, {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}, 3'd1, 4'b0000, 1'b1, '{1'b1, DIR_NONE}}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	cell_t                 map_cell  = '0;
	logic                  done;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	grid_bfs_reach_direction_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.map_cell  (map_cell),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [CFG_POS_W-1:0] start_r_q = 4'd1;
	logic [CFG_POS_W-1:0] start_c_q = 4'd1;
	logic [CFG_POS_W-1:0] goal_r_q  = 4'd8;
	logic [CFG_POS_W-1:0] goal_c_q  = 4'd8;
	logic [CFG_DIM_W-1:0] rows_q    = 5'd10;
	logic [CFG_DIM_W-1:0] cols_q    = 5'd10;
	bit                   wall_mem [CELLS];
	int                   load_pos   = 0;
	int                   loaded_top = 0;

	result_t reach_pending [$];

	int       err_cnt     = 0;
	int       n_cells     = 0;
	int       n_searches  = 0;
	int       n_reached   = 0;
	int       n_cfg       = 0;
	int       n_wraps     = 0;
	bit [4:0] dirs_seen   = '0;
	int       burst_left  = 0;
	int       idle_cycles = 0;

	function automatic int grid_dim(logic [CFG_DIM_W-1:0] v, int hi);
		if (v == '0)
			return 1;
		return (int'(v) > hi) ? hi : int'(v);
	endfunction

	function automatic result_t bfs_reach();
		int      nr, nc, head, tail, cur, r, c, rr, cc, nb, src, goal;
		bit      seen [CELLS];
		move_t   via [CELLS];
		int      fifo [CELLS];
		result_t res;
		res.reachable = 1'b0;
		res.entry_dir = DIR_NONE;
		nr = grid_dim(rows_q, MAX_ROWS);
		nc = grid_dim(cols_q, MAX_COLS);
		if (int'(start_r_q) >= nr || int'(start_c_q) >= nc)
			return res;
		foreach (seen[i])
			seen[i] = 1'b0;
		src = int'(start_r_q) * nc + int'(start_c_q);
		seen[src] = 1'b1;
		fifo[0] = src;
		head = 0;
		tail = 1;
		while (head < tail) begin
			cur = fifo[head];
			head++;
			r = cur / nc;
			c = cur % nc;
			for (int k = 0; k < 4; k++) begin
				rr = r;
				cc = c;
				case (move_t'(k))
					MOVE_UP:    rr = r - 1;
					MOVE_DOWN:  rr = r + 1;
					MOVE_LEFT:  cc = c - 1;
					MOVE_RIGHT: cc = c + 1;
				endcase
				if (rr < 0 || cc < 0 || rr >= nr || cc >= nc)
					continue;
				nb = rr * nc + cc;
				if (wall_mem[nb] || seen[nb])
					continue;
				seen[nb] = 1'b1;
				via[nb] = move_t'(k);
				fifo[tail] = nb;
				tail++;
			end
		end
		if (int'(goal_r_q) >= nr || int'(goal_c_q) >= nc)
			return res;
		goal = int'(goal_r_q) * nc + int'(goal_c_q);
		if (!seen[goal])
			return res;
		res.reachable = 1'b1;
		if (goal != src) begin
			case (via[goal])
				MOVE_UP:    res.entry_dir = DIR_UP;
				MOVE_DOWN:  res.entry_dir = DIR_DOWN;
				MOVE_LEFT:  res.entry_dir = DIR_LEFT;
				MOVE_RIGHT: res.entry_dir = DIR_RIGHT;
			endcase
		end
		return res;
	endfunction

	function automatic void load_map_cell(input cell_t c, output bit has_res,
			output result_t res);
		wall_mem[load_pos] = c.wall_bit;
		load_pos++;
		if (load_pos > loaded_top)
			loaded_top = load_pos;
		if (load_pos >= CELLS) begin
			load_pos = 0;
			if (!c.last_cell)
				n_wraps++;
		end
		has_res = c.last_cell;
		res = '0;
		if (c.last_cell) begin
			load_pos = 0;
			res = bfs_reach();
		end
	endfunction

	function automatic logic [CFG_DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_DIM_W'($urandom_range(MAX_ROWS, 31));
			2:       return CFG_DIM_W'($urandom_range(6, 8));
			default: return CFG_DIM_W'($urandom_range(1, 5));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_pos(int lim);
		if ($urandom_range(0, 6) == 0)
			return CFG_DATA_W'($urandom_range(0, 31));
		return CFG_DATA_W'($urandom_range(0, lim - 1));
	endfunction

	task automatic push_cell(input logic wall, input logic last, input bit known,
			input result_t known_res);
		cell_t   c;
		bit      got;
		result_t res;
		c.wall_bit  = wall;
		c.last_cell = last;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(40, 150);
			end else begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(1, 30);
			end
		end
		start    <= 1'b1;
		map_cell <= c;
		do @(posedge clk); while (busy !== 1'b0);
		burst_left--;
		n_cells++;
		load_map_cell(c, got, res);
		if (got) begin
			if (known)
				res = known_res;
			reach_pending.push_back(res);
			n_searches++;
			if (res.reachable)
				n_reached++;
			dirs_seen[res.entry_dir] = 1'b1;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		if ($urandom_range(0, 3) == 0) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		n_cfg++;
		case (idx)
			REG_START_ROW:  start_r_q = val[CFG_POS_W-1:0];
			REG_START_COL:  start_c_q = val[CFG_POS_W-1:0];
			REG_TARGET_ROW: goal_r_q  = val[CFG_POS_W-1:0];
			REG_TARGET_COL: goal_c_q  = val[CFG_POS_W-1:0];
			REG_ROWS_USED:  rows_q    = val;
			REG_COLS_USED:  cols_q    = val;
			default: ;
		endcase
	endtask

	// no search in flight, then room for one that produces nothing visible yet
	task automatic wait_idle();
		start <= 1'b0;
		while (reach_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_setup(input bit big, input bit new_dims);
		logic [CFG_DIM_W-1:0] rv, cv;
		int                   nr, nc;
		wait_idle();
		if (big) begin
			rv = $urandom_range(0, 1) ? 5'd16 : 5'd31;
			cv = $urandom_range(0, 1) ? 5'd16 : 5'd31;
		end else begin
			rv = pick_dim();
			cv = pick_dim();
			while (grid_dim(rv, MAX_ROWS) * grid_dim(cv, MAX_COLS) > 40)
				cv = CFG_DIM_W'($urandom_range(0, 2));
		end
		if (new_dims) begin
			write_reg(REG_ROWS_USED, rv);
			write_reg(REG_COLS_USED, cv);
		end
		nr = grid_dim(rows_q, MAX_ROWS);
		nc = grid_dim(cols_q, MAX_COLS);
		if (big || $urandom_range(0, 2) != 0)
			write_reg(REG_START_ROW, pick_pos(nr));
		if (big || $urandom_range(0, 2) != 0)
			write_reg(REG_START_COL, pick_pos(nc));
		if (big || $urandom_range(0, 2) != 0)
			write_reg(REG_TARGET_ROW, pick_pos(nr));
		if (big || $urandom_range(0, 2) != 0)
			write_reg(REG_TARGET_COL, pick_pos(nc));
		if ($urandom_range(0, 7) == 0)
			write_reg($urandom_range(0, 1) ? REG_TOP : REG_UNMAPPED,
				CFG_DATA_W'($urandom_range(0, 31)));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_map(input int len, input int wall_pct);
		for (int i = 0; i < len; i++)
			push_cell($urandom_range(0, 99) < wall_pct, i == len - 1, 1'b0, '0);
	endtask

	// result checker; the receiver cannot stall, so every strobe is a transfer
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (reach_pending.size() == 0) begin
				err_cnt++;
				$display("%0t: result with no search pending: reachable=%0b entry_dir=%0d",
					$time, result.reachable, result.entry_dir);
			end else begin
				want = reach_pending.pop_front();
				if (result.reachable !== want.reachable) begin
					err_cnt++;
					$display("%0t: reachable mismatch: expected %0b, actual %0b",
						$time, want.reachable, result.reachable);
				end
				if (result.entry_dir !== want.entry_dir) begin
					err_cnt++;
					$display("%0t: entry_dir mismatch: expected %0d, actual %0d",
						$time, want.entry_dir, result.entry_dir);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int first, map_no, grid_cells, len, pct;
		bit big, force_dims;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIR_TAB[k]) begin
			wait_idle();
			for (int i = 0; i < N_REGS; i++)
				if (DIR_TAB[k].wr_mask[i])
					write_reg(CFG_IDX_W'(i), DIR_TAB[k].wr_val[i*5 +: 5]);
			cfg_valid <= 1'b0;
			for (int i = 0; i < int'(DIR_TAB[k].len); i++)
				push_cell(DIR_TAB[k].walls[i], i == int'(DIR_TAB[k].len) - 1,
					DIR_TAB[k].known, DIR_TAB[k].want);
		end

		first = n_cells;
		map_no = 0;
		force_dims = 1'b1;
		while (n_cells - first < RAND_ITEMS) begin
			big = (map_no == BIG_MAP);
			if (big || force_dims || $urandom_range(0, 3) == 0) begin
				random_setup(big, big || force_dims || $urandom_range(0, 1) == 0);
				force_dims = big;
			end else if ($urandom_range(0, 9) == 0) begin
				wait_idle();
			end
			grid_cells = grid_dim(rows_q, MAX_ROWS) * grid_dim(cols_q, MAX_COLS);
			if (big) begin
				// full grid plus a few cells that wrap onto the first ones
				len = CELLS + $urandom_range(1, 20);
				pct = $urandom_range(0, 20);
			end else begin
				case ($urandom_range(0, 9))
					0: len = (loaded_top >= grid_cells && grid_cells > 1) ?
						$urandom_range(1, grid_cells - 1) : grid_cells;
					1: len = grid_cells + $urandom_range(1, 8);
					default: len = grid_cells;
				endcase
				case ($urandom_range(0, 4))
					0: pct = 0;
					1: pct = 10;
					2: pct = 25;
					3: pct = 40;
					default: pct = $urandom_range(0, 100);
				endcase
			end
			send_map(len, pct);
			map_no++;
		end

		wait_idle();
		$display("run: %0d map cells, %0d searches (%0d reached), %0d register writes, %0d overflows",
			n_cells, n_searches, n_reached, n_cfg, n_wraps);
		$display("run: entry directions seen left/right/up/down/none = %b, grids 1x1 up to 16x16",
			dirs_seen);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
rtl/gbrd_pkg.sv
rtl/gbrd_ram.sv
rtl/gbrd_ctrl.sv
rtl/gbrd_dp.sv
rtl/grid_bfs_reach_direction_core.sv
tb/sv/tb_grid_bfs_reach_direction_core.sv
